### rtl/psi_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the pose interpolator.
// No dependencies.
package psi_pkg;

  localparam int CORDIC_STEPS = 16;

  localparam logic [14:0] THR_RESET = 15'd16376;
  localparam logic [16:0] FRAC_ONE = 17'd65536;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
  localparam logic [33:0] DOT_CLAMP = 34'h0_1000_0000;
  localparam logic signed [33:0] CORDIC_KINV = 34'sd652032874;
  localparam logic signed [67:0] HALF_Q16 = 68'sd32768;

  typedef enum logic [4:0] {
    S_IDLE, S_TR, S_DOT, S_FIX, S_DSQ, S_SQ1_GO, S_SQ1_W, S_LIN,
    S_VEC_GO, S_VEC_W, S_OM, S_ROT_GO, S_ROT_W, S_SL, S_MAG,
    S_SQ2_GO, S_SQ2_W, S_DIV_GO, S_DIV_W, S_FIN
  } psi_state_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0: r = 30'd843314857;
      5'd1: r = 30'd497837829;
      5'd2: r = 30'd263043837;
      5'd3: r = 30'd133525159;
      5'd4: r = 30'd67021687;
      5'd5: r = 30'd33543516;
      5'd6: r = 30'd16775851;
      5'd7: r = 30'd8388437;
      5'd8: r = 30'd4194283;
      5'd9: r = 30'd2097149;
      5'd10: r = 30'd1048576;
      5'd11: r = 30'd524288;
      5'd12: r = 30'd262144;
      5'd13: r = 30'd131072;
      5'd14: r = 30'd65536;
      5'd15: r = 30'd32768;
      5'd16: r = 30'd16384;
      5'd17: r = 30'd8192;
      5'd18: r = 30'd4096;
      5'd19: r = 30'd2048;
      5'd20: r = 30'd1024;
      5'd21: r = 30'd512;
      5'd22: r = 30'd256;
      5'd23: r = 30'd128;
      5'd24: r = 30'd64;
      5'd25: r = 30'd32;
      5'd26: r = 30'd16;
      5'd27: r = 30'd8;
      5'd28: r = 30'd4;
      5'd29: r = 30'd2;
      5'd30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/pose_slerp_interpolator.sv
// Top level: pose store, sequencer and shared multiplier for translation lerp and
// quaternion slerp. Depends on psi_pkg, psi_cordic, psi_isqrt, psi_div.
//
//  channel | signals                              | dir
//  in      | in_valid in_ready req_type pose_* frac | sink
//  out     | out_valid out_ready out_t* out_q*     | source
//  cfg     | cfg_valid cfg_ready cfg_data          | sink
//
// A load item is stored in idle, and the block stays there. A query item runs from
// acceptance to the result register on the blend path or on the slerp path (three
// 16-step CORDIC runs), skips the divisions when the norm is zero, and then returns
// to idle. The divider, run for four components, and the two 32-step roots dominate.
// One 34x34 multiplier is shared by every product, one per cycle.
// Synchronous reset clears pose store and control and sets the threshold to THR_RESET.
// in_ready is low while a query is at work; a finished result waits in the
// output register, and a later query stalls at its end until it is taken.
module pose_slerp_interpolator import psi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic signed [31:0] pose_tx,
  input  logic signed [31:0] pose_ty,
  input  logic signed [31:0] pose_tz,
  input  logic signed [15:0] pose_qx,
  input  logic signed [15:0] pose_qy,
  input  logic signed [15:0] pose_qz,
  input  logic signed [15:0] pose_qw,
  input  logic [16:0]        frac,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_tx,
  output logic signed [31:0] out_ty,
  output logic signed [31:0] out_tz,
  output logic signed [15:0] out_qx,
  output logic signed [15:0] out_qy,
  output logic signed [15:0] out_qz,
  output logic signed [15:0] out_qw,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [14:0]        cfg_data
);

  psi_state_t state, state_next;

  logic signed [31:0] st_t [3];
  logic signed [31:0] en_t [3];
  logic signed [31:0] rt [3];
  logic signed [15:0] st_q [4];
  logic signed [15:0] en_q [4];
  logic signed [15:0] rq [4];
  logic signed [33:0] v [4];

  logic [14:0] thr;
  logic [16:0] fi, gi;
  logic signed [33:0] mul_a, mul_b, omega, s0, s1;
  logic signed [67:0] prod, acc;
  logic [30:0] d;
  logic [31:0] sn, n;
  logic [63:0] sum;
  logic [3:0] cnt, p;
  logic neg, lin, sel;
  logic [1:0] ti;

  logic cor_start, cor_vect, cor_done;
  logic signed [33:0] cor_x0, cor_z0, cor_y, cor_z;
  logic sq_start, sq_done;
  logic [63:0] sq_rad;
  logic [31:0] sq_root;
  logic dv_start, dv_done;
  logic [47:0] dv_num;
  logic [15:0] dv_quo;

  logic in_acc, load_out;
  logic signed [33:0] dot_abs;
  logic signed [67:0] tsum, lsh, lv, dabs;
  logic [15:0] dq;

  function automatic logic signed [33:0] mag_f(input logic signed [33:0] x);
    return x[33] ? -x : x;
  endfunction

  function automatic logic signed [16:0] qb_f(input logic signed [15:0] q, input logic ng);
    logic signed [16:0] e;
    e = 17'(q);
    return ng ? -e : e;
  endfunction

  assign in_ready = (state == S_IDLE);
  assign in_acc = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign p = cnt - 4'd1;
  assign ti = (cnt[2:1] == 2'd3) ? 2'd0 : cnt[2:1];
  assign load_out = (state == S_FIN) && (!out_valid || out_ready);

  assign dabs = acc[67] ? -acc : acc;
  assign dot_abs = dabs[33:0];
  assign tsum = acc + prod;
  assign lsh = (prod + HALF_Q16) >>> 16;
  assign lv = (lsh + 68'(st_q[p[1:0]])) <<< 15;
  assign dq = v[cnt[1:0]][33] ? 16'(-dv_quo) : dv_quo;

  assign cor_start = (state == S_VEC_GO) || (state == S_ROT_GO);
  assign cor_vect = (state == S_VEC_GO);
  assign cor_x0 = cor_vect ? $signed({3'b0, d}) : CORDIC_KINV;
  assign cor_z0 = cor_vect ? 34'sd0 : prod[49:16];
  assign sq_start = (state == S_SQ1_GO) || (state == S_SQ2_GO);
  assign sq_rad = (state == S_SQ1_GO) ? ONE_Q60 - prod[63:0] : sum;
  assign dv_start = (state == S_DIV_GO) && (n != 32'd0);
  assign dv_num = {mag_f(v[cnt[1:0]]), 14'b0} + 48'(n >> 1);

  psi_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cor_start), .vect(cor_vect),
    .x0(cor_x0), .y0(cor_vect ? $signed({2'b0, sn}) : 34'sd0), .z0(cor_z0),
    .done(cor_done), .y(cor_y), .z(cor_z)
  );

  psi_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(sq_start), .rad(sq_rad),
    .done(sq_done), .root(sq_root)
  );

  psi_div u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(n),
    .done(dv_done), .quo(dv_quo)
  );

  always_comb begin
    mul_a = 34'sd0;
    mul_b = 34'sd0;
    case (state)
      S_TR: begin
        mul_a = cnt[0] ? 34'(en_t[ti]) : 34'(st_t[ti]);
        mul_b = cnt[0] ? $signed({17'b0, fi}) : $signed({17'b0, gi});
      end
      S_DOT: begin
        mul_a = 34'(st_q[cnt[1:0]]);
        mul_b = 34'(en_q[cnt[1:0]]);
      end
      S_DSQ: begin
        mul_a = $signed({3'b0, d});
        mul_b = $signed({3'b0, d});
      end
      S_LIN: begin
        mul_a = 34'(qb_f(en_q[cnt[1:0]], neg)) - 34'(st_q[cnt[1:0]]);
        mul_b = $signed({17'b0, fi});
      end
      S_OM: begin
        mul_a = omega;
        mul_b = sel ? $signed({17'b0, fi}) : $signed({17'b0, gi});
      end
      S_SL: begin
        mul_a = cnt[0] ? s1 : s0;
        mul_b = cnt[0] ? 34'(qb_f(en_q[cnt[2:1]], neg)) : 34'(st_q[cnt[2:1]]);
      end
      S_MAG: begin
        mul_a = mag_f(v[cnt[1:0]]);
        mul_b = mag_f(v[cnt[1:0]]);
      end
      default: begin
        mul_a = 34'sd0;
        mul_b = 34'sd0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_acc && req_type) state_next = S_TR;
      S_TR:     if (cnt == 4'd6) state_next = S_DOT;
      S_DOT:    if (cnt == 4'd4) state_next = S_FIX;
      S_FIX:    state_next = S_DSQ;
      S_DSQ:    state_next = S_SQ1_GO;
      S_SQ1_GO: state_next = S_SQ1_W;
      S_SQ1_W: begin
        if (sq_done) state_next = (lin || sq_root == 32'd0) ? S_LIN : S_VEC_GO;
      end
      S_LIN:    if (cnt == 4'd4) state_next = S_MAG;
      S_VEC_GO: state_next = S_VEC_W;
      S_VEC_W:  if (cor_done) state_next = S_OM;
      S_OM:     state_next = S_ROT_GO;
      S_ROT_GO: state_next = S_ROT_W;
      S_ROT_W:  if (cor_done) state_next = sel ? S_SL : S_OM;
      S_SL:     if (cnt == 4'd8) state_next = S_MAG;
      S_MAG:    if (cnt == 4'd4) state_next = S_SQ2_GO;
      S_SQ2_GO: state_next = S_SQ2_W;
      S_SQ2_W:  if (sq_done) state_next = S_DIV_GO;
      S_DIV_GO: begin
        if (n != 32'd0) state_next = S_DIV_W;
        else if (cnt == 4'd3) state_next = S_FIN;
      end
      S_DIV_W:  if (dv_done) state_next = (cnt == 4'd3) ? S_FIN : S_DIV_GO;
      S_FIN:    if (load_out) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
      out_valid <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        st_t[k] <= 32'sd0;
        en_t[k] <= 32'sd0;
      end
      for (int k = 0; k < 4; k++) begin
        st_q[k] <= 16'sd0;
        en_q[k] <= 16'sd0;
      end
    end else begin
      if (cfg_valid) thr <= cfg_data;
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (in_acc && !req_type) begin
        for (int k = 0; k < 3; k++) st_t[k] <= en_t[k];
        for (int k = 0; k < 4; k++) st_q[k] <= en_q[k];
        en_t[0] <= pose_tx;
        en_t[1] <= pose_ty;
        en_t[2] <= pose_tz;
        en_q[0] <= pose_qx;
        en_q[1] <= pose_qy;
        en_q[2] <= pose_qz;
        en_q[3] <= pose_qw;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        fi <= (frac > FRAC_ONE) ? FRAC_ONE : frac;
        gi <= FRAC_ONE - ((frac > FRAC_ONE) ? FRAC_ONE : frac);
        cnt <= 4'd0;
      end
      S_TR: begin
        if (cnt != 4'd0) begin
          if (!p[0]) acc <= prod;
          else rt[p[2:1]] <= 32'((tsum + HALF_Q16) >>> 16);
        end
        if (cnt == 4'd6) begin
          cnt <= 4'd0;
          acc <= 68'sd0;
        end else begin
          cnt <= cnt + 4'd1;
        end
      end
      S_DOT: begin
        if (cnt != 4'd0) acc <= tsum;
        cnt <= (cnt == 4'd4) ? 4'd0 : cnt + 4'd1;
      end
      S_FIX: begin
        neg <= acc[67];
        lin <= dot_abs > $signed({5'b0, thr, 14'b0});
        d <= (dot_abs > $signed(DOT_CLAMP)) ? ONE_Q30 : {dot_abs[28:0], 2'b0};
      end
      S_SQ1_W: begin
        if (sq_done) sn <= sq_root;
      end
      S_LIN: begin
        if (cnt != 4'd0) v[p[1:0]] <= lv[33:0];
        cnt <= (cnt == 4'd4) ? 4'd0 : cnt + 4'd1;
        if (cnt == 4'd4) sum <= 64'd0;
      end
      S_VEC_W: begin
        if (cor_done) begin
          omega <= cor_z;
          sel <= 1'b0;
        end
      end
      S_ROT_W: begin
        if (cor_done) begin
          if (sel) s1 <= cor_y;
          else s0 <= cor_y;
          sel <= 1'b1;
          cnt <= 4'd0;
        end
      end
      S_SL: begin
        if (cnt != 4'd0) begin
          if (!p[0]) acc <= prod;
          else v[p[2:1]] <= 34'(tsum >>> 16);
        end
        cnt <= (cnt == 4'd8) ? 4'd0 : cnt + 4'd1;
        if (cnt == 4'd8) sum <= 64'd0;
      end
      S_MAG: begin
        if (cnt != 4'd0) sum <= sum + prod[63:0];
        cnt <= (cnt == 4'd4) ? 4'd0 : cnt + 4'd1;
      end
      S_SQ2_W: begin
        if (sq_done) begin
          n <= sq_root;
          cnt <= 4'd0;
        end
      end
      S_DIV_GO: begin
        if (n == 32'd0) begin
          rq[cnt[1:0]] <= 16'sd0;
          cnt <= cnt + 4'd1;
        end
      end
      S_DIV_W: begin
        if (dv_done) begin
          rq[cnt[1:0]] <= dq;
          cnt <= cnt + 4'd1;
        end
      end
      S_FIN: begin
        if (load_out) begin
          out_tx <= rt[0];
          out_ty <= rt[1];
          out_tz <= rt[2];
          out_qx <= rq[0];
          out_qy <= rq[1];
          out_qz <= rq[2];
          out_qw <= rq[3];
        end
      end
      default: begin
      end
    endcase
  end

  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    in_acc && req_type |=> state == S_TR)
    else $error("query item did not start the sequencer");

  a_sqrt_done_waited: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> state == S_SQ1_W || state == S_SQ2_W)
    else $error("root finished outside a wait state");

  a_cordic_done_waited: assert property (@(posedge clk) disable iff (rst)
    cor_done |-> state == S_VEC_W || state == S_ROT_W)
    else $error("cordic finished outside a wait state");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_qw) && $stable(out_tx))
    else $error("pending result changed");

endmodule

### rtl/psi_cordic.sv
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// Depends on psi_pkg (step count, arctangent table).
module psi_cordic import psi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               vect,
  input  logic signed [33:0] x0,
  input  logic signed [33:0] y0,
  input  logic signed [33:0] z0,
  output logic               done,
  output logic signed [33:0] y,
  output logic signed [33:0] z
);

  localparam logic [4:0] LAST = 5'(CORDIC_STEPS - 1);

  logic signed [33:0] x, dx, dy, at;
  logic [4:0] cnt;
  logic busy, mode, up;

  assign dx = x >>> cnt;
  assign dy = y >>> cnt;
  assign at = $signed({4'b0, atan_q30(cnt)});
  assign up = mode ? y[33] : !z[33];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x <= x0;
        y <= y0;
        z <= z0;
        mode <= vect;
        cnt <= 5'd0;
        busy <= 1'b1;
      end else if (busy) begin
        if (up) begin
          x <= x - dy;
          y <= y + dx;
          z <= z - at;
        end else begin
          x <= x + dy;
          y <= y - dx;
          z <= z + at;
        end
        cnt <= cnt + 5'd1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/psi_isqrt.sv
// Bit-pair integer square root of a 64-bit value, one result bit per cycle.
// Depends on psi_pkg only by convention.
module psi_isqrt import psi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] rad,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] s, r, b, rb;
  logic [4:0] cnt;
  logic busy;

  assign rb = r + b;
  assign root = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        s <= rad;
        r <= 64'd0;
        b <= 64'h4000_0000_0000_0000;
        cnt <= 5'd0;
        busy <= 1'b1;
      end else if (busy) begin
        if (s >= rb) begin
          s <= s - rb;
          r <= (r >> 1) + b;
        end else begin
          r <= r >> 1;
        end
        b <= b >> 2;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/psi_div.sv
// Restoring divider, 48-bit numerator by 32-bit divisor, one quotient bit per cycle.
// Gives the low 16 quotient bits. Depends on psi_pkg only by convention.
module psi_div import psi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [15:0] quo
);

  logic [31:0] rem, dv;
  logic [47:0] nq;
  logic [32:0] t;
  logic [5:0] cnt;
  logic busy, ge;

  assign t = {rem, nq[47]};
  assign ge = t >= {1'b0, dv};
  assign quo = nq[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= 32'd0;
        nq <= num;
        dv <= den;
        cnt <= 6'd0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? 32'(t - {1'b0, dv}) : t[31:0];
        nq <= {nq[46:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### verif/tb_pose_slerp_interpolator.sv
// Testbench for pose_slerp_interpolator: directed and random load/query items with a
// built-in fixed-point predictor of lerp, slerp and normalisation. Depends on psi_pkg.
`timescale 1ns / 100ps
module tb_pose_slerp_interpolator;
  import psi_pkg::*;

  localparam int DRAIN_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct {
    logic signed [31:0] tx, ty, tz;
    logic signed [15:0] qx, qy, qz, qw;
  } pose_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, req_type = 1'b0;
  logic signed [31:0] pose_tx = '0, pose_ty = '0, pose_tz = '0;
  logic signed [15:0] pose_qx = '0, pose_qy = '0, pose_qz = '0, pose_qw = '0;
  logic [16:0] frac = '0;
  logic out_ready = 1'b0, cfg_valid = 1'b0;
  logic [14:0] cfg_data = '0;
  logic in_ready, out_valid, cfg_ready;
  logic signed [31:0] out_tx, out_ty, out_tz;
  logic signed [15:0] out_qx, out_qy, out_qz, out_qw;

  pose_slerp_interpolator u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
    .pose_tx(pose_tx), .pose_ty(pose_ty), .pose_tz(pose_tz),
    .pose_qx(pose_qx), .pose_qy(pose_qy), .pose_qz(pose_qz), .pose_qw(pose_qw),
    .frac(frac),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_tx(out_tx), .out_ty(out_ty), .out_tz(out_tz),
    .out_qx(out_qx), .out_qy(out_qy), .out_qz(out_qz), .out_qw(out_qw),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [14:0] near_thr;
  logic signed [31:0] start_t[3], end_t[3];
  logic signed [15:0] start_q[4], end_q[4];
  pose_out_t expected_poses[$];

  int errors = 0;
  int n_items = 0, n_queries = 0, n_results = 0, n_linear = 0, n_slerp = 0;
  int snd_idle = 0, rcv_idle = 0, hold_cycles = 0;
  longint cycles = 0;

  const longint atan_q30_tab[16] = '{843314857, 497837829, 263043837, 133525159,
    67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768};

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("** pose_slerp_interpolator: FAILED **");
      $finish;
    end
  end

  function automatic longint unsigned root_u64(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint angle_of(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y >= 0) begin
        x += dy; y -= dx; z += atan_q30_tab[i];
      end else begin
        x -= dy; y += dx; z -= atan_q30_tab[i];
      end
    end
    return z;
  endfunction

  function automatic longint sine_of(longint z);
    longint x, y, dx, dy;
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (z >= 0) begin
        x -= dy; y += dx; z -= atan_q30_tab[i];
      end else begin
        x += dy; y -= dx; z += atan_q30_tab[i];
      end
    end
    return y;
  endfunction

  function automatic pose_out_t interpolate(logic [16:0] f);
    pose_out_t res;
    longint fi, gi, a, b, dot, d, sn, omega, s0, s1;
    longint qa[4], qb[4], v[4], tv[3];
    longint unsigned mag[4], sum, n, r;
    logic [15:0] q[4];
    bit lin;
    fi = (f > FRAC_ONE) ? 65536 : longint'(f);
    gi = 65536 - fi;
    for (int k = 0; k < 3; k++) begin
      a = start_t[k];
      b = end_t[k];
      tv[k] = (a * gi + b * fi + 32768) >>> 16;
    end
    res.tx = tv[0][31:0];
    res.ty = tv[1][31:0];
    res.tz = tv[2][31:0];
    dot = 0;
    for (int k = 0; k < 4; k++) begin
      qa[k] = start_q[k];
      qb[k] = end_q[k];
      dot += qa[k] * qb[k];
    end
    if (dot < 0) begin
      dot = -dot;
      for (int k = 0; k < 4; k++) qb[k] = -qb[k];
    end
    lin = dot > (longint'(near_thr) << 14);
    d = dot * 4;
    if (d > 64'sd1073741824) d = 64'sd1073741824;
    sn = root_u64((64'd1 << 60) - d * d);
    if (sn == 0) lin = 1;
    if (lin) begin
      n_linear++;
      for (int k = 0; k < 4; k++)
        v[k] = (qa[k] + (((qb[k] - qa[k]) * fi + 32768) >>> 16)) * 32768;
    end else begin
      n_slerp++;
      omega = angle_of(sn, d);
      s0 = sine_of((omega * gi) >>> 16);
      s1 = sine_of((omega * fi) >>> 16);
      for (int k = 0; k < 4; k++) v[k] = (s0 * qa[k] + s1 * qb[k]) >>> 16;
    end
    sum = 0;
    for (int k = 0; k < 4; k++) begin
      mag[k] = (v[k] < 0) ? -v[k] : v[k];
      sum += mag[k] * mag[k];
    end
    n = root_u64(sum);
    for (int k = 0; k < 4; k++) begin
      r = 0;
      if (n != 0) begin
        r = (mag[k] * 16384 + n / 2) / n;
        if (v[k] < 0) r = -r;
      end
      q[k] = r[15:0];
    end
    res.qx = q[0]; res.qy = q[1]; res.qz = q[2]; res.qw = q[3];
    return res;
  endfunction

  task automatic send_item(logic rt, logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                           logic [15:0] qx, logic [15:0] qy, logic [15:0] qz,
                           logic [15:0] qw, logic [16:0] f);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    pose_tx <= tx; pose_ty <= ty; pose_tz <= tz;
    pose_qx <= qx; pose_qy <= qy; pose_qz <= qz; pose_qw <= qw;
    frac <= f;
    do @(posedge clk); while (!in_ready);
    n_items++;
    if (rt == REQ_LOAD) begin
      start_t = end_t;
      start_q = end_q;
      end_t = '{tx, ty, tz};
      end_q = '{qx, qy, qz, qw};
    end else begin
      n_queries++;
      expected_poses.push_back(interpolate(f));
    end
  endtask

  task automatic load_pose(logic [15:0] qx, logic [15:0] qy, logic [15:0] qz,
                           logic [15:0] qw);
    send_item(REQ_LOAD, $urandom, $urandom, $urandom, qx, qy, qz, qw, 17'($urandom));
  endtask

  task automatic query_at(logic [16:0] f);
    send_item(REQ_QUERY, $urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), f);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [14:0] thr);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= thr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    near_thr = thr;
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // result side: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    pose_out_t e;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (expected_poses.size() == 0) begin
        errors++;
        $display("%0t unexpected item on output", $time);
      end else begin
        e = expected_poses.pop_front();
        check_field("out_tx", e.tx, out_tx);
        check_field("out_ty", e.ty, out_ty);
        check_field("out_tz", e.tz, out_tz);
        check_field("out_qx", 32'(e.qx), 32'(out_qx));
        check_field("out_qy", 32'(e.qy), 32'(out_qy));
        check_field("out_qz", 32'(e.qz), 32'(out_qz));
        check_field("out_qw", 32'(e.qw), 32'(out_qw));
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  task automatic test_directed();
    query_at(17'd0);                                   // all-zero store: zero norm
    load_pose(16'sh4000, 16'sh0000, 16'sh0000, 16'sh0000);
    load_pose(16'sh4000, 16'sh0000, 16'sh0000, 16'sh0000);
    query_at(17'd32768);                               // identical: sine is zero
    send_item(REQ_LOAD, 32'h7fffffff, 32'h80000000, 32'h00000001,
              16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 17'd0);
    send_item(REQ_LOAD, 32'h80000000, 32'h7fffffff, 32'hffffffff,
              16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 17'd0);
    query_at(17'd65536);                               // dot above one, clamped
    query_at(17'h1ffff);                               // fraction saturates
    load_pose(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    query_at(17'd1);                                   // negative dot, end flipped
    load_pose(16'sh2d41, 16'sh0000, 16'sh0000, 16'sh2d41);
    query_at(17'd16384);
    load_pose(16'sh0000, 16'sh4000, 16'sh0000, 16'sh0000);
    query_at(17'd49152);                               // orthogonal, plain slerp
    query_at(17'd65535);
    load_pose(16'sh4000, 16'sh0000, 16'sh0000, 16'sh0000);
    query_at(17'd0);
    load_pose(16'shc000, 16'sh0000, 16'sh0000, 16'sh0000);
    query_at(17'd32768);                               // opposite: end flipped onto start
  endtask

  task automatic random_items(int count);
    logic [15:0] q[4];
    int step;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 40) begin
        case ($urandom_range(3))
          0: foreach (q[k]) q[k] = 16'($urandom);                  // full range
          1: foreach (q[k]) q[k] = end_q[k];                       // same pose
          2: begin                                                 // near pose
            step = 1 << $urandom_range(8);
            foreach (q[k]) q[k] = 16'(end_q[k] + $urandom_range(2 * step) - step);
          end
          default: foreach (q[k]) q[k] = 16'($signed($urandom_range(32768)) - 16384);
        endcase
        load_pose(q[0], q[1], q[2], q[3]);
      end else begin
        case ($urandom_range(9))
          0: query_at(17'd0);
          1: query_at(17'd65536);
          2: query_at(17'($urandom_range(131071, 65537)));
          default: query_at(17'($urandom_range(65536)));
        endcase
      end
    end
  endtask

  task automatic test_thresholds();
    logic [14:0] thr_set[5] = '{15'd0, 15'd16384, 15'd32767, 15'd12000, THR_RESET};
    foreach (thr_set[i]) begin
      write_threshold(thr_set[i]);
      random_items(40);
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 3000;
    random_items(30);
    wait_drained();
    random_items(20);
  endtask

  task automatic test_idle_profiles();
    snd_idle = 11; rcv_idle = 88;
    random_items(350);
    snd_idle = 88; rcv_idle = 11;
    random_items(350);
    snd_idle = 0; rcv_idle = 0;
    random_items(350);
  endtask

  initial begin
    near_thr = THR_RESET;
    start_t = '{0, 0, 0}; end_t = '{0, 0, 0};
    start_q = '{0, 0, 0, 0}; end_q = '{0, 0, 0, 0};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_thresholds();
    test_backpressure();
    test_idle_profiles();
    wait_drained();
    $display("Sent %0d items (%0d queries), checked %0d results", n_items, n_queries,
             n_results);
    $display("Blend path %0d, slerp path %0d, thresholds 0 to 32767, long stall",
             n_linear, n_slerp);
    if (errors == 0)
      $display("** pose_slerp_interpolator: PASSED **");
    else
      $display("** pose_slerp_interpolator: FAILED **");
    $finish;
  end

endmodule
